// ===== rtl/core/nap_pkg.sv =====
// Shared types and constants for the node address pool with liveness table.
// Used by node_address_pool_liveness_table; depends on nothing else.
package nap_pkg;

  localparam int POOL_ENTRIES   = 255;
  localparam int FIRST_TERMINAL = 11;

  // Index width of the table and the end of the gateway range.
  localparam int ADDR_W  = $clog2(POOL_ENTRIES);
  localparam int GW_END  = (FIRST_TERMINAL < POOL_ENTRIES) ? FIRST_TERMINAL : POOL_ENTRIES;
  localparam bit TERM_EMPTY = (FIRST_TERMINAL >= POOL_ENTRIES);

  localparam logic [1:0] LIVE_MAX = 2'd3;

  localparam logic [2:0] CMD_MARK       = 3'd0;
  localparam logic [2:0] CMD_DEMARK     = 3'd1;
  localparam logic [2:0] CMD_BEST_GW    = 3'd2;
  localparam logic [2:0] CMD_ALLOC_GW   = 3'd3;
  localparam logic [2:0] CMD_ALLOC_TERM = 3'd4;

  typedef struct packed {
    logic       in_use;
    logic [1:0] live;
  } entry_t;

endpackage

// ===== rtl/core/node_address_pool_liveness_table.sv =====
// Node address pool: one table memory of in-use flags and liveness counts.
// Mark and demark read the entry, write it back in ST_UPDATE and present the result from ST_DONE;
// select best gateway scans the whole gateway range; allocations stop at the first free entry
// or the end of their range. The single read port of the table is scanned one entry per cycle.
// One item is in work at a time; the next item is accepted only after ST_DONE hands off its result.
// After reset a clearing sweep writes all 255 entries, one a cycle, with s_tready low.
module node_address_pool_liveness_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [2:0] command, [10:3] node_addr, [15:11] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [7:0] result_addr
);

  localparam int AW = nap_pkg::ADDR_W;
  localparam logic [AW-1:0] LAST_ENTRY = AW'(nap_pkg::POOL_ENTRIES - 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  nap_pkg::entry_t mem [nap_pkg::POOL_ENTRIES];

  logic [2:0]      state, state_next;
  logic [2:0]      cmd_q;
  logic [AW-1:0]   scan_idx, scan_last;
  logic            iss_on;
  logic [1:0]      best_cnt;
  logic [AW-1:0]   res;
  logic            rd_vld;
  logic [AW-1:0]   rd_idx;
  nap_pkg::entry_t rd_data;

  logic            mem_re, mem_we;
  logic [AW-1:0]   mem_raddr, mem_waddr;
  nap_pkg::entry_t mem_wdata, upd;

  logic [2:0]      in_cmd;
  logic [7:0]      in_addr;
  logic            in_acc, addr_ok, out_free, scan_hit, scan_end;

  assign in_cmd   = s_tdata[2:0];
  assign in_addr  = s_tdata[10:3];
  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign addr_ok  = (in_addr < 8'(nap_pkg::POOL_ENTRIES));
  assign out_free = !m_tvalid || m_tready;

  // A scan entry counts as a hit when it is free (allocations only).
  assign scan_hit = rd_vld && (cmd_q != nap_pkg::CMD_BEST_GW) && !rd_data.in_use;
  assign scan_end = rd_vld && (scan_hit || rd_idx == scan_last);

  always_comb begin
    upd = rd_data;
    if (cmd_q == nap_pkg::CMD_MARK) begin
      upd.in_use = 1'b1;
      if (rd_data.live != nap_pkg::LIVE_MAX) upd.live = rd_data.live + 2'd1;
    end else if (rd_data.live != 2'd0) begin
      upd.live = rd_data.live - 2'd1;
    end
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = scan_idx;
    mem_we    = 1'b0;
    mem_waddr = rd_idx;
    mem_wdata = upd;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = scan_idx;
      mem_wdata = '0;
    end else if (state == ST_IDLE) begin
      mem_re    = in_acc && addr_ok &&
                  (in_cmd == nap_pkg::CMD_MARK || in_cmd == nap_pkg::CMD_DEMARK);
      mem_raddr = in_addr[AW-1:0];
    end else if (state == ST_UPDATE) begin
      mem_we = 1'b1;
    end else if (state == ST_SCAN) begin
      mem_re = iss_on;
      // Allocating a gateway claims the found entry, keeping its count.
      if (scan_hit && cmd_q == nap_pkg::CMD_ALLOC_GW) begin
        mem_we    = 1'b1;
        mem_wdata = '{in_use: 1'b1, live: rd_data.live};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
      rd_idx  <= mem_raddr;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (scan_idx == LAST_ENTRY) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_cmd)
            nap_pkg::CMD_MARK, nap_pkg::CMD_DEMARK:
              state_next = addr_ok ? ST_UPDATE : ST_DONE;
            nap_pkg::CMD_BEST_GW, nap_pkg::CMD_ALLOC_GW: state_next = ST_SCAN;
            nap_pkg::CMD_ALLOC_TERM:
              state_next = nap_pkg::TERM_EMPTY ? ST_DONE : ST_SCAN;
            default:   state_next = ST_DONE;
          endcase
        end
      end
      ST_UPDATE: state_next = ST_DONE;
      ST_SCAN:   if (scan_end) state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      scan_idx <= '0;
      iss_on   <= 1'b0;
      rd_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= mem_re;
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: scan_idx <= scan_idx + 1'b1;
        ST_IDLE: begin
          iss_on <= in_acc;
          if (in_acc) begin
            unique case (in_cmd)
              nap_pkg::CMD_BEST_GW: begin
                scan_idx  <= '0;
                scan_last <= AW'(nap_pkg::GW_END - 1);
              end
              nap_pkg::CMD_ALLOC_GW: begin
                scan_idx  <= AW'(1);
                scan_last <= AW'(nap_pkg::GW_END - 1);
              end
              default: begin
                scan_idx  <= AW'(nap_pkg::FIRST_TERMINAL);
                scan_last <= LAST_ENTRY;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (iss_on) begin
            scan_idx <= scan_idx + 1'b1;
            if (scan_idx == scan_last) iss_on <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Result and best-count tracking; payload only.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      res      <= '0;
      best_cnt <= '0;
    end else if (state == ST_SCAN && rd_vld) begin
      if (cmd_q == nap_pkg::CMD_BEST_GW) begin
        if (rd_data.live > best_cnt) begin
          best_cnt <= rd_data.live;
          res      <= rd_idx;
        end
      end else if (scan_hit) begin
        res <= rd_idx;
      end
    end
    if (in_acc) cmd_q <= in_cmd;
    if (state == ST_DONE && out_free) m_tdata <= 8'(res);
  end

  a_scan_write_only_alloc_gw: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && mem_we) |-> cmd_q == nap_pkg::CMD_ALLOC_GW)
    else $error("table written during a scan that does not allocate a gateway");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && rd_vld) |-> rd_idx <= scan_last)
    else $error("scan read beyond its range");

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> m_tvalid)
    else $error("finished item not presented on the output");

  a_term_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && cmd_q == nap_pkg::CMD_ALLOC_TERM && res != '0)
      |-> res >= AW'(nap_pkg::FIRST_TERMINAL))
    else $error("terminal allocation returned a gateway address");

endmodule

// ===== test/tb.sv =====
// Testbench for node_address_pool_liveness_table: drives command items and checks
// every result address against a scoreboard that tracks the in-use flags and liveness counts.
// Depends on nap_pkg and the block's RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1100;
  localparam int HOLD_CYCLES = 400;

  // Tracks the address table and the result addresses still due from the block.
  class pool_tracker;
    bit         in_use [nap_pkg::POOL_ENTRIES];
    bit [1:0]   live [nap_pkg::POOL_ENTRIES];
    logic [7:0] pending_addrs [$];
    int         errors;
    int         checked;

    function new();
      foreach (in_use[i]) begin
        in_use[i] = 1'b0;
        live[i]   = 2'd0;
      end
      errors  = 0;
      checked = 0;
    endfunction

    function void apply_command(logic [2:0] cmd, logic [7:0] addr);
      logic [7:0] res;
      bit [1:0]   best_live;
      res = 8'd0;
      case (cmd)
        nap_pkg::CMD_MARK: begin
          if (addr < nap_pkg::POOL_ENTRIES) begin
            in_use[addr] = 1'b1;
            if (live[addr] != nap_pkg::LIVE_MAX) live[addr] = live[addr] + 2'd1;
          end
        end
        nap_pkg::CMD_DEMARK: begin
          if (addr < nap_pkg::POOL_ENTRIES && live[addr] != 2'd0) begin
            live[addr] = live[addr] - 2'd1;
          end
        end
        nap_pkg::CMD_BEST_GW: begin
          // Only a strictly higher count wins, so ties go to the lowest address.
          best_live = 2'd0;
          for (int i = 0; i < nap_pkg::GW_END; i++) begin
            if (live[i] > best_live) begin
              best_live = live[i];
              res = 8'(i);
            end
          end
        end
        nap_pkg::CMD_ALLOC_GW: begin
          for (int i = 1; i < nap_pkg::GW_END && res == 8'd0; i++) begin
            if (!in_use[i]) res = 8'(i);
          end
          if (res != 8'd0) in_use[res] = 1'b1;
        end
        nap_pkg::CMD_ALLOC_TERM: begin
          for (int i = nap_pkg::FIRST_TERMINAL;
               i < nap_pkg::POOL_ENTRIES && res == 8'd0; i++) begin
            if (!in_use[i]) res = 8'(i);
          end
        end
        default: ;
      endcase
      pending_addrs.push_back(res);
    endfunction

    function void check_result(logic [7:0] actual);
      logic [7:0] expected;
      if (pending_addrs.size() == 0) begin
        $error("result_addr: unexpected item, expected none, actual %0d", actual);
        errors++;
      end else begin
        expected = pending_addrs.pop_front();
        checked++;
        if (actual !== expected) begin
          $error("result_addr mismatch: expected %0d, actual %0d", expected, actual);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;

  pool_tracker pool;
  int  sent_items;
  int  stall_cycles;
  int  hold_left;
  bit  hold_request;
  bit  gaps_on;

  node_address_pool_liveness_table DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Ends the run when nothing moves on either side for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side: checks each accepted item, then picks the next ready value.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) pool.check_result(m_tdata);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(gaps_on && $urandom_range(99) < 6);
      end
    end
  end

  task automatic send_command(input logic [2:0] cmd, input logic [7:0] addr);
    while (gaps_on && $urandom_range(99) < 6) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, addr, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pool.apply_command(cmd, addr);
    sent_items++;
  endtask

  function automatic logic [2:0] pick_command();
    int r;
    r = $urandom_range(99);
    if (r < 35) return nap_pkg::CMD_MARK;
    if (r < 65) return nap_pkg::CMD_DEMARK;
    if (r < 80) return nap_pkg::CMD_BEST_GW;
    if (r < 88) return nap_pkg::CMD_ALLOC_GW;
    if (r < 96) return nap_pkg::CMD_ALLOC_TERM;
    return 3'(nap_pkg::CMD_ALLOC_TERM + 1 + $urandom_range(2));
  endfunction

  // Most addresses land in the gateway range or low terminals, where the scans look.
  function automatic logic [7:0] pick_addr();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 8'($urandom_range(nap_pkg::GW_END - 1));
    if (r < 80) return 8'(nap_pkg::FIRST_TERMINAL + $urandom_range(29));
    if (r < 95) return 8'($urandom_range(255));
    return $urandom_range(1) ? 8'd255 : 8'd254;
  endfunction

  initial begin
    pool = new();
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = 16'd0;
    m_tready     = 1'b0;
    sent_items   = 0;
    stall_cycles = 0;
    hold_left    = 0;
    hold_request = 1'b0;
    gaps_on      = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty table, first allocations, saturation, ties, floors and out-of-range items.
    send_command(nap_pkg::CMD_BEST_GW, 8'd85);
    send_command(nap_pkg::CMD_ALLOC_TERM, 8'd0);
    send_command(nap_pkg::CMD_ALLOC_GW, 8'd255);
    repeat (4) send_command(nap_pkg::CMD_MARK, 8'd0);
    repeat (3) send_command(nap_pkg::CMD_MARK, 8'd10);
    send_command(nap_pkg::CMD_BEST_GW, 8'd0);
    repeat (4) send_command(nap_pkg::CMD_DEMARK, 8'd0);
    send_command(nap_pkg::CMD_BEST_GW, 8'd170);
    send_command(nap_pkg::CMD_MARK, 8'd255);
    send_command(nap_pkg::CMD_DEMARK, 8'd255);
    send_command(nap_pkg::CMD_DEMARK, 8'd254);
    send_command(nap_pkg::CMD_MARK, 8'd254);
    send_command(nap_pkg::CMD_MARK, 8'd11);
    send_command(nap_pkg::CMD_ALLOC_TERM, 8'd0);
    send_command(3'(nap_pkg::CMD_ALLOC_TERM + 1), 8'd255);
    send_command(3'(nap_pkg::CMD_ALLOC_TERM + 2), 8'd0);
    send_command(3'(nap_pkg::CMD_ALLOC_TERM + 3), 8'd170);
    send_command(nap_pkg::CMD_ALLOC_GW, 8'd85);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 200) hold_request = 1'b1;
      gaps_on = !(n >= 400 && n < 650);
      send_command(pick_command(), pick_addr());
    end

    // Fill every terminal address so the terminal scan runs dry, then probe the scans.
    for (int a = nap_pkg::FIRST_TERMINAL; a < nap_pkg::POOL_ENTRIES; a++) begin
      send_command(nap_pkg::CMD_MARK, 8'(a));
    end
    send_command(nap_pkg::CMD_ALLOC_TERM, 8'd0);
    send_command(nap_pkg::CMD_ALLOC_GW, 8'd0);
    send_command(nap_pkg::CMD_BEST_GW, 8'd0);
    s_tvalid <= 1'b0;

    while (pool.pending_addrs.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d command items and checked %0d result items, including a full terminal",
             sent_items, pool.checked);
    $display("range, gateway exhaustion, count saturation and a long receiver hold-off.");
    if (pool.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/nap_pkg.sv
rtl/core/node_address_pool_liveness_table.sv
test/tb.sv
